>>> sv/lrct_pkg.sv
// Shared types, constants and helpers for the label region crack contour tracer.
// Depends on nothing; used by label_region_crack_contour_tracer.
package lrct_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam int COORD_W = 11;
    localparam int LABEL_W = 15;
    localparam int CFG_W   = 15;

    localparam logic [LABEL_W-1:0] LABEL_OUTSIDE = 15'h7FFF;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_FETCH   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_TARGET = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_CHK,
        ST_SCAN_CMP,
        ST_GATHER,
        ST_SCAN_EVAL,
        ST_TRACE_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_EDGE,
        PH_CORNER
    } phase_t;

    typedef struct packed {
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
    } pos_t;

    // 4-neighbour in direction side: 0 left, 1 up, 2 right, 3 down (wraps)
    function automatic pos_t nb(input pos_t p, input logic [1:0] side);
        pos_t q;
        q = p;
        unique case (side)
            2'd0: q.c = p.c - COORD_W'(1);
            2'd1: q.r = p.r - COORD_W'(1);
            2'd2: q.c = p.c + COORD_W'(1);
            2'd3: q.r = p.r + COORD_W'(1);
        endcase
        return q;
    endfunction

    // half-pixel offsets of edge and corner points
    function automatic logic [1:0] edge_oc(input logic [1:0] s);
        logic [1:0] v;
        unique case (s)
            2'd0: v = 2'd0;
            2'd1: v = 2'd1;
            2'd2: v = 2'd2;
            2'd3: v = 2'd1;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] edge_or(input logic [1:0] s);
        logic [1:0] v;
        unique case (s)
            2'd0: v = 2'd1;
            2'd1: v = 2'd0;
            2'd2: v = 2'd1;
            2'd3: v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] corn_oc(input logic [1:0] s);
        return (s == 2'd1 || s == 2'd2) ? 2'd2 : 2'd0;
    endfunction

    function automatic logic [1:0] corn_or(input logic [1:0] s);
        return s[1] ? 2'd2 : 2'd0;
    endfunction

endpackage

>>> sv/label_region_crack_contour_tracer.sv
// Crack-following contour tracer over a label frame store with visited marks.
// Depends on lrct_pkg.
//
// Usage: one request channel (in_valid/in_stall) carries kind and pixel fields.
// A load request writes one pixel label into the frame store and clears its
// visited mark. A restart request puts the scan cursor back at row 1 column 1
// and drops any open trace. A fetch request returns exactly one point on the
// result channel (out_valid/out_stall). A fetch within a contour reads four
// pixels through the single read port of the frame store. A fetch that must
// scan checks each pixel in turn, gathers the four neighbours of each
// unvisited pixel of the target label and moves to the next row at each
// row end, so its latency grows with the distance to the next border.
// in_stall is high while a request is being worked on. A finished point sits
// in the output register until taken; loads and restarts are still accepted
// meanwhile, a further fetch waits for the output register to drain.
// Reset: configuration returns to target 1 and 128 x 128, the scan cursor to
// row 1 column 1, no trace open. Frame store contents are undefined until
// loaded; visited marks are kept across restarts.
module label_region_crack_contour_tracer #(
    parameter int MAX_WIDTH  = lrct_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lrct_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [1:0]                    cfg_index,
    input  logic [lrct_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [6:0]                    pixel_row,
    input  logic [6:0]                    pixel_col,
    input  logic [14:0]                   pixel_label,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [8:0]                    point_col_half,
    output logic [8:0]                    point_row_half,
    output logic [1:0]                    edge_side,
    output logic                          is_corner,
    output logic                          contour_last,
    output logic                          scan_done
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = lrct_pkg::COORD_W;
    localparam int LW     = lrct_pkg::LABEL_W;

    // frame store
    logic [LW:0]         mem [DEPTH];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [LW:0]         mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [LW:0]         rd_data_reg;
    logic                rd_out_reg, rd_out_next;

    // control and datapath registers
    lrct_pkg::state_t    state_reg, state_next;
    lrct_pkg::phase_t    phase_reg, phase_next;
    lrct_pkg::pos_t      scan_reg, scan_next;
    lrct_pkg::pos_t      tr_reg, tr_next;
    logic [1:0]          dir_reg, dir_next;
    lrct_pkg::pos_t      st_reg, st_next;
    logic [1:0]          st_side_reg, st_side_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [LW:0]         val_reg [4];
    logic [LW:0]         val_next [4];
    logic [LW-1:0]       target_reg, target_next;
    logic [7:0]          width_reg, width_next;
    logic [7:0]          height_reg, height_next;

    logic                out_valid_reg, out_valid_next;
    logic [8:0]          col_reg, col_next;
    logic [8:0]          row_reg, row_next;
    logic [1:0]          oside_reg, oside_next;
    logic                corner_reg, corner_next;
    logic                last_reg, last_next;
    logic                done_reg, done_next;

    // combinational helpers
    logic                accept;
    logic                slot_free;
    logic [CW-1:0]       w_eff, h_eff;
    logic [LW:0]         pix;
    lrct_pkg::pos_t      rd_pos;
    lrct_pkg::pos_t      g_base, g_pos;
    logic [1:0]          g_side;
    lrct_pkg::pos_t      p_n, p_b, p_d;
    logic [LW-1:0]       la, ln, lb, ld;
    logic                is_corner_pt;
    lrct_pkg::pos_t      mv_pos;
    logic [1:0]          mv_side;
    logic                mv_last;
    logic                scan_hit;
    logic [1:0]          scan_side;
    logic [1:0]          cnt_m1;
    logic                load_ok;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != lrct_pkg::ST_IDLE);

    assign out_valid      = out_valid_reg;
    assign point_col_half = col_reg;
    assign point_row_half = row_reg;
    assign edge_side      = oside_reg;
    assign is_corner      = corner_reg;
    assign contour_last   = last_reg;
    assign scan_done      = done_reg;

    assign w_eff = (32'(width_reg) < MAX_WIDTH) ? CW'(width_reg) : CW'(MAX_WIDTH);
    assign h_eff = (32'(height_reg) < MAX_HEIGHT) ? CW'(height_reg) : CW'(MAX_HEIGHT);

    // pixels outside the image read as the outside label, unvisited
    assign pix = rd_out_reg ? {1'b0, lrct_pkg::LABEL_OUTSIDE} : rd_data_reg;

    assign cnt_m1 = cnt_reg[1:0] - 2'd1;

    // gather positions: scan mode reads the four neighbours of the cursor,
    // trace mode reads center, side, next side and the diagonal
    assign g_base = (phase_reg == lrct_pkg::PH_SCAN) ? scan_reg : tr_reg;
    assign p_n    = lrct_pkg::nb(tr_reg, dir_reg);
    assign p_b    = lrct_pkg::nb(tr_reg, dir_reg + 2'd1);
    assign p_d    = lrct_pkg::nb(p_b, dir_reg);
    assign g_side = cnt_reg[1:0];

    always_comb
    begin
        g_pos = g_base;
        if (phase_reg == lrct_pkg::PH_SCAN)
        begin
            g_pos = lrct_pkg::nb(scan_reg, g_side);
        end
        else
        begin
            unique case (g_side)
                2'd0: g_pos = tr_reg;
                2'd1: g_pos = p_n;
                2'd2: g_pos = p_b;
                2'd3: g_pos = p_d;
            endcase
        end
    end

    assign la = val_reg[0][LW-1:0];
    assign ln = val_reg[1][LW-1:0];
    assign lb = val_reg[2][LW-1:0];
    assign ld = val_reg[3][LW-1:0];

    assign is_corner_pt = (lb != la && lb != ln) || (ld != la && ld != ln);

    always_comb
    begin
        mv_pos  = tr_reg;
        mv_side = dir_reg;
        priority if (la == ld)
        begin
            mv_pos  = p_d;
            mv_side = dir_reg + 2'd3;
        end
        else if (la != lb)
        begin
            mv_side = dir_reg + 2'd1;
        end
        else
        begin
            mv_pos = p_b;
        end
    end

    assign mv_last = (mv_pos == st_reg) && (mv_side == st_side_reg);

    // first neighbour of another label, in side order
    always_comb
    begin
        scan_hit  = 1'b1;
        scan_side = 2'd0;
        priority if (val_reg[0][LW-1:0] != target_reg) scan_side = 2'd0;
        else if (val_reg[1][LW-1:0] != target_reg)     scan_side = 2'd1;
        else if (val_reg[2][LW-1:0] != target_reg)     scan_side = 2'd2;
        else if (val_reg[3][LW-1:0] != target_reg)     scan_side = 2'd3;
        else                                           scan_hit  = 1'b0;
    end

    assign load_ok = (32'(pixel_row) < MAX_HEIGHT) && (32'(pixel_col) < MAX_WIDTH);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrct_pkg::ST_IDLE:
            begin
                if (accept && kind == lrct_pkg::KIND_FETCH)
                begin
                    priority if (phase_reg != lrct_pkg::PH_SCAN)
                        state_next = lrct_pkg::ST_GATHER;
                    else if (target_reg == lrct_pkg::LABEL_OUTSIDE)
                        state_next = lrct_pkg::ST_DONE;
                    else
                        state_next = lrct_pkg::ST_SCAN_CHK;
                end
            end
            lrct_pkg::ST_SCAN_CHK:
            begin
                priority if (!(scan_reg.r + CW'(1) < h_eff))
                    state_next = lrct_pkg::ST_DONE;
                else if (scan_reg.c + CW'(1) < w_eff)
                    state_next = lrct_pkg::ST_SCAN_CMP;
                else
                    state_next = lrct_pkg::ST_SCAN_CHK;
            end
            lrct_pkg::ST_SCAN_CMP:
            begin
                if (pix == {1'b0, target_reg})
                    state_next = lrct_pkg::ST_GATHER;
                else
                    state_next = lrct_pkg::ST_SCAN_CHK;
            end
            lrct_pkg::ST_GATHER:
            begin
                if (cnt_reg == 3'd4)
                    state_next = (phase_reg == lrct_pkg::PH_SCAN) ?
                                 lrct_pkg::ST_SCAN_EVAL : lrct_pkg::ST_TRACE_EVAL;
            end
            lrct_pkg::ST_SCAN_EVAL:
            begin
                state_next = scan_hit ? lrct_pkg::ST_GATHER : lrct_pkg::ST_SCAN_CHK;
            end
            lrct_pkg::ST_TRACE_EVAL,
            lrct_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = lrct_pkg::ST_IDLE;
            end
            default: state_next = lrct_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        scan_next      = scan_reg;
        tr_next        = tr_reg;
        dir_next       = dir_reg;
        st_next        = st_reg;
        st_side_next   = st_side_reg;
        cnt_next       = cnt_reg;
        for (int i = 0; i < 4; i++)
            val_next[i] = val_reg[i];
        target_next    = target_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        out_valid_next = out_valid_reg && out_stall;
        col_next       = col_reg;
        row_next       = row_reg;
        oside_next     = oside_reg;
        corner_next    = corner_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        rd_pos         = scan_reg;

        if (cfg_write_en)
        begin
            unique case (lrct_pkg::cfg_index_t'(cfg_index))
                lrct_pkg::CFG_TARGET: target_next = cfg_data[LW-1:0];
                lrct_pkg::CFG_WIDTH:  width_next  = cfg_data[7:0];
                lrct_pkg::CFG_HEIGHT: height_next = cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            lrct_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    unique case (lrct_pkg::kind_t'(kind))
                        lrct_pkg::KIND_LOAD:
                        begin
                            mem_we    = load_ok;
                            mem_waddr = ADDR_W'(32'(pixel_row) * MAX_WIDTH + 32'(pixel_col));
                            mem_wdata = {1'b0, pixel_label};
                        end
                        lrct_pkg::KIND_RESTART:
                        begin
                            scan_next  = '{r: CW'(1), c: CW'(1)};
                            phase_next = lrct_pkg::PH_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            lrct_pkg::ST_SCAN_CHK:
            begin
                cnt_next = '0;
                if (scan_reg.r + CW'(1) < h_eff)
                begin
                    if (scan_reg.c + CW'(1) < w_eff)
                    begin
                        mem_re = 1'b1;
                        rd_pos = scan_reg;
                    end
                    else
                    begin
                        scan_next.r = scan_reg.r + CW'(1);
                        scan_next.c = CW'(1);
                    end
                end
            end
            lrct_pkg::ST_SCAN_CMP:
            begin
                if (pix != {1'b0, target_reg})
                    scan_next.c = scan_reg.c + CW'(1);
            end
            lrct_pkg::ST_GATHER:
            begin
                if (cnt_reg != 3'd4)
                begin
                    mem_re = 1'b1;
                    rd_pos = g_pos;
                end
                if (cnt_reg != 3'd0)
                    val_next[cnt_m1] = pix;
                cnt_next = (cnt_reg == 3'd4) ? 3'd0 : cnt_reg + 3'd1;
            end
            lrct_pkg::ST_SCAN_EVAL:
            begin
                if (scan_hit)
                begin
                    tr_next      = scan_reg;
                    dir_next     = scan_side;
                    st_next      = scan_reg;
                    st_side_next = scan_side;
                    phase_next   = lrct_pkg::PH_EDGE;
                end
                else
                begin
                    scan_next.c = scan_reg.c + CW'(1);
                end
            end
            lrct_pkg::ST_TRACE_EVAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    oside_next     = dir_reg;
                    done_next      = 1'b0;
                    if (phase_reg == lrct_pkg::PH_CORNER)
                    begin
                        col_next    = {tr_reg.c[7:0], 1'b0} + 9'(lrct_pkg::corn_oc(dir_reg));
                        row_next    = {tr_reg.r[7:0], 1'b0} + 9'(lrct_pkg::corn_or(dir_reg));
                        corner_next = 1'b1;
                        last_next   = mv_last;
                        tr_next     = mv_pos;
                        dir_next    = mv_side;
                        phase_next  = mv_last ? lrct_pkg::PH_SCAN : lrct_pkg::PH_EDGE;
                    end
                    else
                    begin
                        // mark the pixel the trace stands on
                        mem_we      = (tr_reg.r < h_eff) && (tr_reg.c < w_eff);
                        mem_waddr   = ADDR_W'(32'(tr_reg.r) * MAX_WIDTH + 32'(tr_reg.c));
                        mem_wdata   = {1'b1, la};
                        col_next    = {tr_reg.c[7:0], 1'b0} + 9'(lrct_pkg::edge_oc(dir_reg));
                        row_next    = {tr_reg.r[7:0], 1'b0} + 9'(lrct_pkg::edge_or(dir_reg));
                        corner_next = 1'b0;
                        if (is_corner_pt)
                        begin
                            last_next  = 1'b0;
                            phase_next = lrct_pkg::PH_CORNER;
                        end
                        else
                        begin
                            last_next  = mv_last;
                            tr_next    = mv_pos;
                            dir_next   = mv_side;
                            phase_next = mv_last ? lrct_pkg::PH_SCAN : lrct_pkg::PH_EDGE;
                        end
                    end
                end
            end
            lrct_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    col_next       = '0;
                    row_next       = '0;
                    oside_next     = '0;
                    corner_next    = 1'b0;
                    last_next      = 1'b0;
                    done_next      = 1'b1;
                    phase_next     = lrct_pkg::PH_SCAN;
                end
            end
            default: ;
        endcase

        rd_out_next = mem_re ? !((rd_pos.r < h_eff) && (rd_pos.c < w_eff)) : rd_out_reg;
        mem_raddr   = rd_out_next ? '0 :
                      ADDR_W'(32'(rd_pos.r) * MAX_WIDTH + 32'(rd_pos.c));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrct_pkg::ST_IDLE;
            phase_reg     <= lrct_pkg::PH_SCAN;
            scan_reg      <= '{r: CW'(1), c: CW'(1)};
            tr_reg        <= '0;
            dir_reg       <= '0;
            st_reg        <= '0;
            st_side_reg   <= '0;
            cnt_reg       <= '0;
            target_reg    <= LW'(1);
            width_reg     <= 8'd128;
            height_reg    <= 8'd128;
            out_valid_reg <= 1'b0;
            rd_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            scan_reg      <= scan_next;
            tr_reg        <= tr_next;
            dir_reg       <= dir_next;
            st_reg        <= st_next;
            st_side_reg   <= st_side_next;
            cnt_reg       <= cnt_next;
            target_reg    <= target_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
            rd_out_reg    <= rd_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            val_reg[i] <= val_next[i];
        col_reg    <= col_next;
        row_reg    <= row_next;
        oside_reg  <= oside_next;
        corner_reg <= corner_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

endmodule

>>> verif/label_region_crack_contour_tracer_tb.sv
// Self-checking testbench for label_region_crack_contour_tracer: loads label
// images, fetches contour points and checks them against an in-bench tracer.
// Depends on lrct_pkg and the label_region_crack_contour_tracer RTL.
module label_region_crack_contour_tracer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W = 128;
    localparam int STORE_H = 128;
    localparam int ITEM_GOAL = 1450;
    localparam int IDLE_LIMIT = 250000;

    typedef struct packed {
        logic [8:0] col_half;
        logic [8:0] row_half;
        logic [1:0] side;
        logic       corner;
        logic       last;
        logic       done;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [6:0]  pixel_row;
    logic [6:0]  pixel_col;
    logic [14:0] pixel_label;
    logic        out_valid;
    logic        out_stall;
    logic [8:0]  point_col_half;
    logic [8:0]  point_row_half;
    logic [1:0]  edge_side;
    logic        is_corner;
    logic        contour_last;
    logic        scan_done;

    label_region_crack_contour_tracer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .pixel_row(pixel_row), .pixel_col(pixel_col), .pixel_label(pixel_label),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_col_half(point_col_half), .point_row_half(point_row_half),
        .edge_side(edge_side), .is_corner(is_corner),
        .contour_last(contour_last), .scan_done(scan_done)
    );

    // shadow of the block
    logic [15:0] pix_store [STORE_W*STORE_H];
    bit          pix_written [STORE_W*STORE_H];
    logic [14:0] tgt_label;
    logic [7:0]  img_w;
    logic [7:0]  img_h;
    int          cursor_r, cursor_c;
    int          walk_r, walk_c, walk_s;
    int          start_r, start_c, start_s;
    lrct_pkg::phase_t trc_phase;

    point_t      pending_points[$];
    int          errors;
    int          items_sent;
    int          points_seen;
    int          contours_seen;
    int          idle_cycles;
    bit          quiet;

    const int dr[4] = '{0, -1, 0, 1};
    const int dc[4] = '{-1, 0, 1, 0};
    const int e_oc[4] = '{0, 1, 2, 1};
    const int e_or[4] = '{1, 0, 1, 2};
    const int c_oc[4] = '{0, 2, 2, 0};
    const int c_or[4] = '{0, 0, 2, 2};

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int used_w();
        return (img_w < STORE_W) ? int'(img_w) : STORE_W;
    endfunction

    function automatic int used_h();
        return (img_h < STORE_H) ? int'(img_h) : STORE_H;
    endfunction

    function automatic logic [15:0] raw_pix(int r, int c);
        r = r & 2047;
        c = c & 2047;
        if (r >= used_h() || c >= used_w())
            return 16'h7FFF;
        return pix_store[r*STORE_W + c];
    endfunction

    function automatic logic [14:0] label_of(int r, int c);
        return 15'(raw_pix(r, c));
    endfunction

    function automatic bit corner_here(int r, int c, int s);
        logic [14:0] a, n, b, d;
        int s1;
        s1 = (s + 1) & 3;
        a = label_of(r, c);
        n = label_of(r + dr[s], c + dc[s]);
        b = label_of(r + dr[s1], c + dc[s1]);
        d = label_of(r + dr[s1] + dr[s], c + dc[s1] + dc[s]);
        return (b != a && b != n) || (d != a && d != n);
    endfunction

    // advance one crack step; report closure of the contour
    function automatic bit walk_step();
        int s1, r1, c1, rd, cd;
        logic [14:0] a;
        s1 = (walk_s + 1) & 3;
        a = label_of(walk_r, walk_c);
        r1 = (walk_r + dr[s1]) & 2047;
        c1 = (walk_c + dc[s1]) & 2047;
        rd = (r1 + dr[walk_s]) & 2047;
        cd = (c1 + dc[walk_s]) & 2047;
        if (a == label_of(rd, cd)) begin
            walk_r = rd;
            walk_c = cd;
            walk_s = (walk_s + 3) & 3;
        end else if (a != label_of(r1, c1)) begin
            walk_s = s1;
        end else begin
            walk_r = r1;
            walk_c = c1;
        end
        return walk_r == start_r && walk_c == start_c && walk_s == start_s;
    endfunction

    function automatic bit seek_border();
        int r, c, s;
        bit found;
        r = cursor_r;
        c = cursor_c;
        found = 0;
        if (tgt_label != 15'h7FFF) begin
            while (!found && r + 1 < used_h()) begin
                while (c + 1 < used_w()) begin
                    if (raw_pix(r, c) == {1'b0, tgt_label}) begin
                        for (s = 0; s < 4; s++)
                            if (label_of(r + dr[s], c + dc[s]) != tgt_label)
                                break;
                        if (s < 4) begin
                            walk_r = r;
                            walk_c = c;
                            walk_s = s;
                            start_r = r;
                            start_c = c;
                            start_s = s;
                            found = 1;
                            break;
                        end
                    end
                    c++;
                end
                if (!found) begin
                    r++;
                    c = 1;
                end
            end
        end
        cursor_r = r;
        cursor_c = c;
        return found;
    endfunction

    function automatic point_t next_point();
        point_t p;
        int r, c, s;
        bit last;
        p = '0;
        if (trc_phase != lrct_pkg::PH_EDGE && trc_phase != lrct_pkg::PH_CORNER) begin
            if (!seek_border()) begin
                trc_phase = lrct_pkg::PH_SCAN;
                p.done = 1'b1;
                return p;
            end
            trc_phase = lrct_pkg::PH_EDGE;
        end
        r = walk_r;
        c = walk_c;
        s = walk_s;
        p.side = 2'(s);
        if (trc_phase == lrct_pkg::PH_CORNER) begin
            last = walk_step();
            trc_phase = last ? lrct_pkg::PH_SCAN : lrct_pkg::PH_EDGE;
            p.col_half = 9'(2*c + c_oc[s]);
            p.row_half = 9'(2*r + c_or[s]);
            p.corner = 1'b1;
            p.last = last;
            return p;
        end
        if (r < used_h() && c < used_w())
            pix_store[r*STORE_W + c][15] = 1'b1;
        if (corner_here(r, c, s)) begin
            trc_phase = lrct_pkg::PH_CORNER;
            last = 0;
        end else begin
            last = walk_step();
            trc_phase = last ? lrct_pkg::PH_SCAN : lrct_pkg::PH_EDGE;
        end
        p.col_half = 9'(2*c + e_oc[s]);
        p.row_half = 9'(2*r + e_or[s]);
        p.last = last;
        return p;
    endfunction

    function automatic int gap_len();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(lrct_pkg::kind_t k, int r = 0, int c = 0, int lab = 0);
        repeat (gap_len()) @(negedge clk);
        in_valid = 1'b1;
        kind = k;
        pixel_row = 7'(r);
        pixel_col = 7'(c);
        pixel_label = 15'(lab);
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        case (k)
            lrct_pkg::KIND_LOAD:
            begin
                pix_store[r*STORE_W + c] = {1'b0, 15'(lab)};
                pix_written[r*STORE_W + c] = 1;
            end
            lrct_pkg::KIND_RESTART:
            begin
                cursor_r = 1;
                cursor_c = 1;
                trc_phase = lrct_pkg::PH_SCAN;
            end
            lrct_pkg::KIND_FETCH:
                pending_points.push_back(next_point());
            default:;
        endcase
        @(negedge clk);
        in_valid = 1'b0;
        kind = 2'($urandom_range(0, 3));
        pixel_label = 15'($urandom);
    endtask

    task automatic settle();
        wait (pending_points.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(lrct_pkg::cfg_index_t idx, int val);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = 15'(val);
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            lrct_pkg::CFG_TARGET: tgt_label = 15'(val);
            lrct_pkg::CFG_WIDTH:  img_w = 8'(val);
            lrct_pkg::CFG_HEIGHT: img_h = 8'(val);
            default:;
        endcase
    endtask

    task automatic set_frame(int tgt, int w, int h);
        settle();
        write_reg(lrct_pkg::CFG_TARGET, tgt);
        write_reg(lrct_pkg::CFG_WIDTH, w);
        write_reg(lrct_pkg::CFG_HEIGHT, h);
    endtask

    // load every unwritten pixel in use so no fetch reads an unwritten entry
    task automatic fill_unwritten(int lab_a, int lab_b);
        for (int r = 0; r < used_h(); r++)
            for (int c = 0; c < used_w(); c++)
                if (!pix_written[r*STORE_W + c])
                    send(lrct_pkg::KIND_LOAD, r, c,
                         ($urandom_range(0, 2) == 0) ? lab_b : lab_a);
    endtask

    task automatic fetch_until_done(int cap);
        for (int i = 0; i < cap; i++) begin
            send(lrct_pkg::KIND_FETCH);
            wait (pending_points.size() == 0);
            if (scan_done)
                break;
        end
    endtask

    task automatic test_smallest_frame();
        set_frame(1, 3, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send(lrct_pkg::KIND_LOAD, r, c,
                     (r == 1 && c == 1) ? 1 : ((r + c) % 2 ? 0 : 32767));
        fetch_until_done(20);
        send(lrct_pkg::KIND_FETCH);
        send(lrct_pkg::KIND_NONE);
        send(lrct_pkg::KIND_RESTART);
        send(lrct_pkg::KIND_FETCH);
        send(lrct_pkg::KIND_LOAD, 127, 127, 32767);
        send(lrct_pkg::KIND_LOAD, 1, 1, 1);
        send(lrct_pkg::KIND_FETCH);
        settle();
    endtask

    task automatic test_unreachable_target();
        set_frame(32767, 3, 3);
        send(lrct_pkg::KIND_RESTART);
        send(lrct_pkg::KIND_FETCH);
        set_frame(0, 3, 3);
        send(lrct_pkg::KIND_RESTART);
        send(lrct_pkg::KIND_FETCH);
        send(lrct_pkg::KIND_FETCH);
        settle();
    endtask

    task automatic test_wide_and_tall();
        set_frame(5, 128, 3);
        fill_unwritten(5, 6);
        send(lrct_pkg::KIND_RESTART);
        fetch_until_done(60);
        set_frame(5, 3, 128);
        fill_unwritten(5, 32767);
        send(lrct_pkg::KIND_RESTART);
        fetch_until_done(60);
        settle();
    endtask

    task automatic test_random_traffic();
        int w, h, tgt, ops, pick;
        while (items_sent < ITEM_GOAL) begin
            quiet = ($urandom_range(0, 4) == 0);
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 10);
            tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 3);
            set_frame(tgt, w, h);
            fill_unwritten(tgt, 4);
            // fresh pattern: relabel part of the frame, which also clears marks
            for (int i = 0; i < w*h/2; i++)
                send(lrct_pkg::KIND_LOAD, $urandom_range(0, h-1), $urandom_range(0, w-1),
                     ($urandom_range(0, 1) == 0) ? tgt : $urandom_range(1, 4));
            send(lrct_pkg::KIND_RESTART);
            ops = $urandom_range(30, 80);
            for (int i = 0; i < ops; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send(lrct_pkg::KIND_FETCH);
                else if (pick < 88)
                    send(lrct_pkg::KIND_LOAD, $urandom_range(0, h-1), $urandom_range(0, w-1),
                         $urandom_range(0, 4));
                else if (pick < 92)
                    send(lrct_pkg::KIND_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 32767));
                else if (pick < 96)
                    send(lrct_pkg::KIND_RESTART);
                else
                    send(lrct_pkg::KIND_NONE);
            end
        end
        quiet = 0;
        settle();
    endtask

    // result receiver: random stall, checked against the oldest expectation
    int stall_left;
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall = 1'b1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            out_stall = 1'b1;
        end else begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk) begin
        point_t want;
        if (rst_n && out_valid && !out_stall) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                $error("unexpected point col %0d row %0d", point_col_half, point_row_half);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (contour_last)
                    contours_seen++;
                if (point_col_half !== want.col_half) begin
                    $error("point_col_half exp %0d got %0d", want.col_half, point_col_half);
                    errors++;
                end
                if (point_row_half !== want.row_half) begin
                    $error("point_row_half exp %0d got %0d", want.row_half, point_row_half);
                    errors++;
                end
                if (edge_side !== want.side) begin
                    $error("edge_side exp %0d got %0d", want.side, edge_side);
                    errors++;
                end
                if (is_corner !== want.corner) begin
                    $error("is_corner exp %0d got %0d", want.corner, is_corner);
                    errors++;
                end
                if (contour_last !== want.last) begin
                    $error("contour_last exp %0d got %0d", want.last, contour_last);
                    errors++;
                end
                if (scan_done !== want.done) begin
                    $error("scan_done exp %0d got %0d", want.done, scan_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or point moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = lrct_pkg::CFG_TARGET;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = lrct_pkg::KIND_NONE;
        pixel_row = '0;
        pixel_col = '0;
        pixel_label = '0;
        out_stall = 1'b0;
        stall_left = 0;
        quiet = 0;
        errors = 0;
        items_sent = 0;
        points_seen = 0;
        contours_seen = 0;
        idle_cycles = 0;
        for (int i = 0; i < STORE_W*STORE_H; i++) begin
            pix_store[i] = '0;
            pix_written[i] = 0;
        end
        tgt_label = 15'd1;
        img_w = 8'd128;
        img_h = 8'd128;
        cursor_r = 1;
        cursor_c = 1;
        walk_r = 0;
        walk_c = 0;
        walk_s = 0;
        start_r = 0;
        start_c = 0;
        start_s = 0;
        trc_phase = lrct_pkg::PH_SCAN;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_smallest_frame();
        test_unreachable_target();
        test_wide_and_tall();
        test_random_traffic();

        wait (pending_points.size() == 0);
        repeat (50) @(negedge clk);
        $display("Sent %0d requests; checked %0d points over %0d closed contours.",
                 items_sent, points_seen, contours_seen);
        $display("Frames from 3x3 up to 128 wide and 128 tall, with loads during traces.");
        if (errors == 0 && pending_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
